### hdl/cbp_pkg.sv
// Shared constants and types for the circle and box penetration pipeline.
`default_nettype none

package cbp_pkg;

  // Coordinate width of the signed Q11.4 inputs and push outputs.
  localparam int COORD_WIDTH = 15;
  // Radius and half size are unsigned, one bit narrower than a coordinate.
  localparam int RAD_WIDTH = COORD_WIDTH - 1;
  // Differences and clamped offsets need two more bits than a coordinate.
  localparam int DIFF_WIDTH = COORD_WIDTH + 2;
  // Squared length of an offset whose components are within the radius.
  localparam int SQ_WIDTH = 2 * RAD_WIDTH + 1;
  // Root bits needed to cover the full squared length range.
  localparam int ROOT_BITS = RAD_WIDTH + 1;

  // Square root pipeline: two root bits are resolved in each stage.
  localparam int SQRT_STEPS_PER_STAGE = 2;
  localparam int SQRT_STAGES =
      (ROOT_BITS + SQRT_STEPS_PER_STAGE - 1) / SQRT_STEPS_PER_STAGE;
  localparam int SQRT_ITERS = SQRT_STAGES * SQRT_STEPS_PER_STAGE;
  localparam int RADICAND_WIDTH = 2 * SQRT_ITERS;
  localparam int REM_WIDTH = SQRT_ITERS + 3;

  // Half size after reset.
  localparam logic [RAD_WIDTH-1:0] HALF_SIZE_RESET = RAD_WIDTH'(256);

  // Push direction, in priority order for ties.
  typedef enum logic [1:0] {
    DIR_POS_X,
    DIR_POS_Y,
    DIR_NEG_X,
    DIR_NEG_Y
  } cbp_dir_t;

  // Per-item data that rides along the square root pipeline.
  typedef struct packed {
    logic                 no_hit;
    cbp_dir_t             dir;
    logic [RAD_WIDTH-1:0] radius;
  } cbp_tag_t;

endpackage

`default_nettype wire

### hdl/cbp_front.sv
// Front pipeline: box offset, clamp, range check, direction and squared length.
`default_nettype none

module cbp_front (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic        [cbp_pkg::RAD_WIDTH-1:0]       half_size,
  input  logic                                       in_valid,
  output logic                                       in_ready,
  input  logic signed [cbp_pkg::COORD_WIDTH-1:0]     circle_x,
  input  logic signed [cbp_pkg::COORD_WIDTH-1:0]     circle_y,
  input  logic        [cbp_pkg::RAD_WIDTH-1:0]       circle_radius,
  input  logic signed [cbp_pkg::COORD_WIDTH-1:0]     box_x,
  input  logic signed [cbp_pkg::COORD_WIDTH-1:0]     box_y,
  output logic                                       out_valid,
  input  logic                                       out_ready,
  output logic        [cbp_pkg::RADICAND_WIDTH-1:0]  radicand,
  output cbp_pkg::cbp_tag_t                          tag
);

  // Stage A registers: box center minus circle center.
  logic                                   a_valid;
  logic signed [cbp_pkg::DIFF_WIDTH-1:0]  a_ex;
  logic signed [cbp_pkg::DIFF_WIDTH-1:0]  a_ey;
  logic        [cbp_pkg::RAD_WIDTH-1:0]   a_radius;

  // Stage B registers: offset from the circle center to the closest point.
  logic                                   b_valid;
  logic signed [cbp_pkg::DIFF_WIDTH-1:0]  b_dx;
  logic signed [cbp_pkg::DIFF_WIDTH-1:0]  b_dy;
  logic        [cbp_pkg::RAD_WIDTH-1:0]   b_radius;

  // Stage C registers: squares and the partial tag.
  logic                                   c_valid;
  logic        [2*cbp_pkg::RAD_WIDTH-1:0] c_sqx;
  logic        [2*cbp_pkg::RAD_WIDTH-1:0] c_sqy;
  logic        [2*cbp_pkg::RAD_WIDTH-1:0] c_r2;
  cbp_pkg::cbp_tag_t                      c_tag;

  // Stage D registers: squared length and final tag.
  logic                                   d_valid;
  logic        [cbp_pkg::RADICAND_WIDTH-1:0] d_radicand;
  cbp_pkg::cbp_tag_t                      d_tag;

  // Stage advance enables; a stage loads when it is empty or drains.
  logic adv_a, adv_b, adv_c, adv_d;

  assign adv_d    = !d_valid || out_ready;
  assign adv_c    = !c_valid || adv_d;
  assign adv_b    = !b_valid || adv_c;
  assign adv_a    = !a_valid || adv_b;
  assign in_ready = adv_a;

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
      d_valid <= 1'b0;
    end else begin
      if (adv_a) a_valid <= in_valid;
      if (adv_b) b_valid <= a_valid;
      if (adv_c) c_valid <= b_valid;
      if (adv_d) d_valid <= c_valid;
    end
  end

  // Stage A: differences of the centers.
  always_ff @(posedge clk) begin
    if (adv_a && in_valid) begin
      a_ex     <= cbp_pkg::DIFF_WIDTH'(box_x) - cbp_pkg::DIFF_WIDTH'(circle_x);
      a_ey     <= cbp_pkg::DIFF_WIDTH'(box_y) - cbp_pkg::DIFF_WIDTH'(circle_y);
      a_radius <= circle_radius;
    end
  end

  // Stage B: clamp onto the box. The offset is the box edge minus the center
  // when the center lies outside that edge, and zero inside.
  logic signed [cbp_pkg::DIFF_WIDTH-1:0] half_s;
  logic signed [cbp_pkg::DIFF_WIDTH-1:0] lo_x, hi_x, lo_y, hi_y;
  logic signed [cbp_pkg::DIFF_WIDTH-1:0] dx_next, dy_next;

  assign half_s = signed'(cbp_pkg::DIFF_WIDTH'(half_size));
  assign lo_x   = a_ex - half_s;
  assign hi_x   = a_ex + half_s;
  assign lo_y   = a_ey - half_s;
  assign hi_y   = a_ey + half_s;

  always_comb begin
    if (lo_x > 0) begin
      dx_next = lo_x;
    end else if (hi_x < 0) begin
      dx_next = hi_x;
    end else begin
      dx_next = '0;
    end
    if (lo_y > 0) begin
      dy_next = lo_y;
    end else if (hi_y < 0) begin
      dy_next = hi_y;
    end else begin
      dy_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_b && a_valid) begin
      b_dx     <= dx_next;
      b_dy     <= dy_next;
      b_radius <= a_radius;
    end
  end

  // Stage C: magnitudes, the per-axis range check, direction and squares.
  logic        [cbp_pkg::DIFF_WIDTH-1:0] adx, ady;
  logic                                  far;
  logic signed [cbp_pkg::DIFF_WIDTH-1:0] best_val;
  cbp_pkg::cbp_dir_t                     dir_next;

  assign adx = b_dx[cbp_pkg::DIFF_WIDTH-1] ? unsigned'(-b_dx) : unsigned'(b_dx);
  assign ady = b_dy[cbp_pkg::DIFF_WIDTH-1] ? unsigned'(-b_dy) : unsigned'(b_dy);
  assign far = (adx > cbp_pkg::DIFF_WIDTH'(b_radius)) ||
               (ady > cbp_pkg::DIFF_WIDTH'(b_radius));

  // The first strictly largest of dx, dy, -dx, -dy picks the direction.
  always_comb begin
    best_val = b_dx;
    dir_next = cbp_pkg::DIR_POS_X;
    if (b_dy > best_val) begin
      best_val = b_dy;
      dir_next = cbp_pkg::DIR_POS_Y;
    end
    if (-b_dx > best_val) begin
      best_val = -b_dx;
      dir_next = cbp_pkg::DIR_NEG_X;
    end
    if (-b_dy > best_val) begin
      dir_next = cbp_pkg::DIR_NEG_Y;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_c && b_valid) begin
      c_sqx        <= adx[cbp_pkg::RAD_WIDTH-1:0] * adx[cbp_pkg::RAD_WIDTH-1:0];
      c_sqy        <= ady[cbp_pkg::RAD_WIDTH-1:0] * ady[cbp_pkg::RAD_WIDTH-1:0];
      c_r2         <= b_radius * b_radius;
      c_tag.no_hit <= far;
      c_tag.dir    <= dir_next;
      c_tag.radius <= b_radius;
    end
  end

  // Stage D: squared length and its compare against the squared radius.
  logic [cbp_pkg::SQ_WIDTH-1:0] len2;

  assign len2 = cbp_pkg::SQ_WIDTH'(c_sqx) + cbp_pkg::SQ_WIDTH'(c_sqy);

  always_ff @(posedge clk) begin
    if (adv_d && c_valid) begin
      d_radicand   <= cbp_pkg::RADICAND_WIDTH'(len2);
      d_tag.no_hit <= c_tag.no_hit || (len2 > cbp_pkg::SQ_WIDTH'(c_r2));
      d_tag.dir    <= c_tag.dir;
      d_tag.radius <= c_tag.radius;
    end
  end

  assign out_valid = d_valid;
  assign radicand  = d_radicand;
  assign tag       = d_tag;

endmodule

`default_nettype wire

### hdl/cbp_sqrt.sv
// Pipelined truncating integer square root, a fixed number of root bits per stage.
`default_nettype none

module cbp_sqrt (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      in_valid,
  output logic                                      in_ready,
  input  logic [cbp_pkg::RADICAND_WIDTH-1:0]        radicand,
  input  cbp_pkg::cbp_tag_t                         in_tag,
  output logic                                      out_valid,
  input  logic                                      out_ready,
  output logic [cbp_pkg::SQRT_ITERS-1:0]            root,
  output cbp_pkg::cbp_tag_t                         out_tag
);

  localparam int NS = cbp_pkg::SQRT_STAGES;

  // Partial remainder, partial root and the radicand bits still to consume.
  typedef struct packed {
    logic [cbp_pkg::REM_WIDTH-1:0]      rem;
    logic [cbp_pkg::SQRT_ITERS-1:0]     root;
    logic [cbp_pkg::RADICAND_WIDTH-1:0] rad;
  } sqrt_state_t;

  // Digit-by-digit restoring square root, a few root bits per call.
  function automatic sqrt_state_t sqrt_step(input sqrt_state_t s);
    sqrt_state_t                   t;
    logic [cbp_pkg::REM_WIDTH-1:0] cur;
    logic [cbp_pkg::REM_WIDTH-1:0] trial;
    t = s;
    for (int i = 0; i < cbp_pkg::SQRT_STEPS_PER_STAGE; i++) begin
      cur   = {t.rem[cbp_pkg::REM_WIDTH-3:0], t.rad[cbp_pkg::RADICAND_WIDTH-1 -: 2]};
      trial = cbp_pkg::REM_WIDTH'({t.root, 2'b01});
      t.rad = t.rad << 2;
      if (cur >= trial) begin
        t.rem  = cur - trial;
        t.root = {t.root[cbp_pkg::SQRT_ITERS-2:0], 1'b1};
      end else begin
        t.rem  = cur;
        t.root = {t.root[cbp_pkg::SQRT_ITERS-2:0], 1'b0};
      end
    end
    return t;
  endfunction

  logic              [NS-1:0] st_valid;
  logic              [NS:0]   adv;
  sqrt_state_t                st_q   [NS];
  cbp_pkg::cbp_tag_t          tag_q  [NS];
  sqrt_state_t                st_in  [NS];
  cbp_pkg::cbp_tag_t          tag_in [NS];
  logic              [NS-1:0] vin;

  assign adv[NS]  = out_ready;
  assign in_ready = adv[0];

  // Each stage resolves its share of root bits from the previous stage.
  for (genvar k = 0; k < NS; k++) begin : g_stage
    if (k == 0) begin : g_first
      assign st_in[k]  = '{rem: '0, root: '0, rad: radicand};
      assign tag_in[k] = in_tag;
      assign vin[k]    = in_valid;
    end else begin : g_next
      assign st_in[k]  = st_q[k-1];
      assign tag_in[k] = tag_q[k-1];
      assign vin[k]    = st_valid[k-1];
    end

    assign adv[k] = !st_valid[k] || adv[k+1];

    always_ff @(posedge clk) begin
      if (rst) begin
        st_valid[k] <= 1'b0;
      end else if (adv[k]) begin
        st_valid[k] <= vin[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv[k] && vin[k]) begin
        st_q[k]  <= sqrt_step(st_in[k]);
        tag_q[k] <= tag_in[k];
      end
    end
  end

  assign out_valid = st_valid[NS-1];
  assign root      = st_q[NS-1].root;
  assign out_tag   = tag_q[NS-1];

endmodule

`default_nettype wire

### hdl/cbp_back.sv
// Output stage: depth from the root, push vector selection and output register.
`default_nettype none

module cbp_back (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic        [cbp_pkg::SQRT_ITERS-1:0]  root,
  input  cbp_pkg::cbp_tag_t                      tag,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic                                   hit,
  output logic signed [cbp_pkg::COORD_WIDTH-1:0] push_x,
  output logic signed [cbp_pkg::COORD_WIDTH-1:0] push_y
);

  logic        [cbp_pkg::RAD_WIDTH-1:0]   depth;
  logic signed [cbp_pkg::COORD_WIDTH-1:0] depth_pos;
  logic signed [cbp_pkg::COORD_WIDTH-1:0] depth_neg;
  logic signed [cbp_pkg::COORD_WIDTH-1:0] px_next;
  logic signed [cbp_pkg::COORD_WIDTH-1:0] py_next;
  logic                                   load;

  // On a hit the root never exceeds the radius, so the depth is non-negative.
  assign depth     = tag.radius - root[cbp_pkg::RAD_WIDTH-1:0];
  assign depth_pos = signed'(cbp_pkg::COORD_WIDTH'(depth));
  assign depth_neg = -depth_pos;

  // Place the depth on the chosen axis; a miss gives a zero push.
  always_comb begin
    px_next = '0;
    py_next = '0;
    if (!tag.no_hit) begin
      case (tag.dir)
        cbp_pkg::DIR_POS_X: px_next = depth_pos;
        cbp_pkg::DIR_POS_Y: py_next = depth_pos;
        cbp_pkg::DIR_NEG_X: px_next = depth_neg;
        cbp_pkg::DIR_NEG_Y: py_next = depth_neg;
        default:            px_next = depth_pos;
      endcase
    end
  end

  assign in_ready = !out_valid || out_ready;
  assign load     = in_ready && in_valid;

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      hit    <= !tag.no_hit;
      push_x <= px_next;
      push_y <= py_next;
    end
  end

endmodule

`default_nettype wire

### hdl/circle_box_penetration.sv
// Top level of the circle against square box penetration pipeline.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-----------------------------------
//   cfg     | in        | cfg_valid/cfg_ready  | box_half_size
//   in      | in        | in_valid/in_ready    | circle_x, circle_y, circle_radius,
//           |           |                      | box_x, box_y
//   out     | out       | out_valid/out_ready  | hit, push_x, push_y
//
// One item enters per cycle while the output is not stalled, and each passes
// four front stages (center difference, clamp, squares, length compare), eight
// square root stages at two root bits each, and the output register to its result.
// Reset clears all valid bits and sets the half size to 256.
// A stall at the output fills empty stages first; no item is lost or repeated.
// Configuration writes are taken every cycle and apply to items entering the clamp.
`default_nettype none

module circle_box_penetration (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic        [cbp_pkg::RAD_WIDTH-1:0]   box_half_size,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [cbp_pkg::COORD_WIDTH-1:0] circle_x,
  input  logic signed [cbp_pkg::COORD_WIDTH-1:0] circle_y,
  input  logic        [cbp_pkg::RAD_WIDTH-1:0]   circle_radius,
  input  logic signed [cbp_pkg::COORD_WIDTH-1:0] box_x,
  input  logic signed [cbp_pkg::COORD_WIDTH-1:0] box_y,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic                                   hit,
  output logic signed [cbp_pkg::COORD_WIDTH-1:0] push_x,
  output logic signed [cbp_pkg::COORD_WIDTH-1:0] push_y
);

  // Half size register.
  logic [cbp_pkg::RAD_WIDTH-1:0] half_size;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_size <= cbp_pkg::HALF_SIZE_RESET;
    end else if (cfg_valid) begin
      half_size <= box_half_size;
    end
  end

  // Front to square root link.
  logic                                 fr_valid;
  logic                                 fr_ready;
  logic [cbp_pkg::RADICAND_WIDTH-1:0]   fr_radicand;
  cbp_pkg::cbp_tag_t                    fr_tag;

  // Square root to output link.
  logic                                 sq_valid;
  logic                                 sq_ready;
  logic [cbp_pkg::SQRT_ITERS-1:0]       sq_root;
  cbp_pkg::cbp_tag_t                    sq_tag;

  cbp_front u_front (
    .clk           (clk),
    .rst           (rst),
    .half_size     (half_size),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .circle_x      (circle_x),
    .circle_y      (circle_y),
    .circle_radius (circle_radius),
    .box_x         (box_x),
    .box_y         (box_y),
    .out_valid     (fr_valid),
    .out_ready     (fr_ready),
    .radicand      (fr_radicand),
    .tag           (fr_tag)
  );

  cbp_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fr_valid),
    .in_ready  (fr_ready),
    .radicand  (fr_radicand),
    .in_tag    (fr_tag),
    .out_valid (sq_valid),
    .out_ready (sq_ready),
    .root      (sq_root),
    .out_tag   (sq_tag)
  );

  cbp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sq_valid),
    .in_ready  (sq_ready),
    .root      (sq_root),
    .tag       (sq_tag),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .hit       (hit),
    .push_x    (push_x),
    .push_y    (push_y)
  );

endmodule

`default_nettype wire

### hdl/cbp_checker.sv
// Port-level checks for the penetration pipeline, bound to the top level.
`default_nettype none

module cbp_checker (
  input logic                                   clk,
  input logic                                   rst,
  input logic                                   out_valid,
  input logic                                   out_ready,
  input logic                                   hit,
  input logic signed [cbp_pkg::COORD_WIDTH-1:0] push_x,
  input logic signed [cbp_pkg::COORD_WIDTH-1:0] push_y
);

  // A stalled result holds its value until taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(hit) && $stable(push_x) &&
                                $stable(push_y))
    else $error("result changed while stalled");

  // No result is shown right after reset.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

  // A miss carries a zero push.
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !hit |-> push_x == 0 && push_y == 0)
    else $error("nonzero push on a miss");

  // The push lies along one axis only.
  a_one_axis: assert property (@(posedge clk) disable iff (rst)
    out_valid && hit |-> push_x == 0 || push_y == 0)
    else $error("push on both axes");

endmodule

bind circle_box_penetration cbp_checker u_cbp_checker (.*);

`default_nettype wire

### tb/penetration_checker.sv
// Checker that predicts each circle and box penetration result and compares it with the block.
`default_nettype none

module penetration_checker (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_valid,
  input  logic                                   cfg_ready,
  input  logic        [cbp_pkg::RAD_WIDTH-1:0]   box_half_size,
  input  logic                                   in_valid,
  input  logic                                   in_ready,
  input  logic signed [cbp_pkg::COORD_WIDTH-1:0] circle_x,
  input  logic signed [cbp_pkg::COORD_WIDTH-1:0] circle_y,
  input  logic        [cbp_pkg::RAD_WIDTH-1:0]   circle_radius,
  input  logic signed [cbp_pkg::COORD_WIDTH-1:0] box_x,
  input  logic signed [cbp_pkg::COORD_WIDTH-1:0] box_y,
  input  logic                                   out_valid,
  input  logic                                   out_ready,
  input  logic                                   hit,
  input  logic signed [cbp_pkg::COORD_WIDTH-1:0] push_x,
  input  logic signed [cbp_pkg::COORD_WIDTH-1:0] push_y,
  output int                                     mismatch_count,
  output int                                     outstanding
);
  import cbp_pkg::*;

  localparam int PRINT_LIMIT = 100;

  typedef struct {
    logic                          hit;
    logic signed [COORD_WIDTH-1:0] push_x;
    logic signed [COORD_WIDTH-1:0] push_y;
  } penetration_t;

  penetration_t         predicted_pushes[$];
  logic [RAD_WIDTH-1:0] half_size;
  int                   lines_printed;

  initial begin
    mismatch_count = 0;
    outstanding = 0;
    lines_printed = 0;
    half_size = HALF_SIZE_RESET;
  end

  // Offset from a circle center to the nearest point of the box along one axis.
  // The box edges are kept at full width so that they never wrap.
  function automatic logic signed [DIFF_WIDTH-1:0] clamp_offset(
    input logic signed [COORD_WIDTH-1:0] pos,
    input logic signed [COORD_WIDTH-1:0] mid,
    input logic        [RAD_WIDTH-1:0]   half
  );
    logic signed [DIFF_WIDTH-1:0] lo_side;
    logic signed [DIFF_WIDTH-1:0] hi_side;
    logic signed [DIFF_WIDTH-1:0] nearest;
    lo_side = mid - $signed({1'b0, half});
    hi_side = mid + $signed({1'b0, half});
    nearest = pos;
    if (pos < lo_side) begin
      nearest = lo_side;
    end else if (pos > hi_side) begin
      nearest = hi_side;
    end
    return nearest - pos;
  endfunction

  // Expected hit flag and push vector for one query.
  function automatic penetration_t predict_penetration(
    input logic signed [COORD_WIDTH-1:0] cx,
    input logic signed [COORD_WIDTH-1:0] cy,
    input logic        [RAD_WIDTH-1:0]   radius,
    input logic signed [COORD_WIDTH-1:0] bx,
    input logic signed [COORD_WIDTH-1:0] by,
    input logic        [RAD_WIDTH-1:0]   half
  );
    penetration_t                  res;
    logic signed [DIFF_WIDTH-1:0]  dx;
    logic signed [DIFF_WIDTH-1:0]  dy;
    logic signed [DIFF_WIDTH-1:0]  best;
    logic        [DIFF_WIDTH-1:0]  adx;
    logic        [DIFF_WIDTH-1:0]  ady;
    logic        [SQ_WIDTH-1:0]    len_sq;
    logic        [SQ_WIDTH-1:0]    rad_sq;
    logic        [ROOT_BITS-1:0]   root;
    logic        [ROOT_BITS-1:0]   trial;
    logic        [2*ROOT_BITS-1:0] trial_sq;
    logic        [RAD_WIDTH-1:0]   depth;
    logic signed [COORD_WIDTH-1:0] push;
    cbp_dir_t                      dir;
    res.hit = 1'b0;
    res.push_x = '0;
    res.push_y = '0;
    dx = clamp_offset(cx, bx, half);
    dy = clamp_offset(cy, by, half);
    adx = (dx < 0) ? -dx : dx;
    ady = (dy < 0) ? -dy : dy;

    // Either axis alone past the radius, or the squared length past it, is a miss.
    if (adx > radius || ady > radius) begin
      return res;
    end
    len_sq = adx * adx + ady * ady;
    rad_sq = radius * radius;
    if (len_sq > rad_sq) begin
      return res;
    end

    // Truncating square root, one root bit at a time from the top.
    root = '0;
    for (int b = ROOT_BITS - 1; b >= 0; b--) begin
      trial = root | (ROOT_BITS'(1) << b);
      trial_sq = trial * trial;
      if (trial_sq <= len_sq) begin
        root = trial;
      end
    end
    depth = radius - root[RAD_WIDTH-1:0];

    // Strictly largest component wins; ties keep the earlier direction.
    dir = DIR_POS_X;
    best = dx;
    if (dy > best) begin
      dir = DIR_POS_Y;
      best = dy;
    end
    if (-dx > best) begin
      dir = DIR_NEG_X;
      best = -dx;
    end
    if (-dy > best) begin
      dir = DIR_NEG_Y;
      best = -dy;
    end

    push = $signed({1'b0, depth});
    res.hit = 1'b1;
    case (dir)
      DIR_POS_X: res.push_x = push;
      DIR_POS_Y: res.push_y = push;
      DIR_NEG_X: res.push_x = -push;
      default:   res.push_y = -push;
    endcase
    return res;
  endfunction

  // Prints one line per mismatch, up to a limit, and counts every one.
  task automatic report_mismatch(input string what, input int got_v, input int want_v);
    mismatch_count++;
    if (lines_printed < PRINT_LIMIT) begin
      $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got_v, want_v);
      lines_printed++;
    end
  endtask

  // Track the half size, queue a prediction for each query and check each result.
  always @(posedge clk) begin
    penetration_t want;
    if (rst) begin
      half_size <= HALF_SIZE_RESET;
      predicted_pushes.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        half_size <= box_half_size;
      end
      if (in_valid && in_ready) begin
        predicted_pushes.push_back(predict_penetration(circle_x, circle_y, circle_radius,
                                                       box_x, box_y, half_size));
      end
      if (out_valid && out_ready) begin
        if (predicted_pushes.size() == 0) begin
          report_mismatch("result with no query waiting, hit", hit, 0);
        end else begin
          want = predicted_pushes.pop_front();
          if (hit !== want.hit) begin
            report_mismatch("hit", hit, want.hit);
          end
          if (push_x !== want.push_x) begin
            report_mismatch("push_x", push_x, want.push_x);
          end
          if (push_y !== want.push_y) begin
            report_mismatch("push_y", push_y, want.push_y);
          end
        end
      end
    end
    outstanding <= predicted_pushes.size();
  end

endmodule

`default_nettype wire

### tb/circle_box_penetration_test.sv
// Testbench top: drives circle and box queries and half-size writes, and gives the verdict.
`default_nettype none

module circle_box_penetration_test;
  import cbp_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES = 20;
  localparam int RANDOM_PHASES = 8;
  localparam int ITEMS_PER_PHASE = 216;
  localparam int MODE_PERIOD = 300;
  localparam int COORD_MIN = -(1 << (COORD_WIDTH - 1));
  localparam int COORD_MAX = (1 << (COORD_WIDTH - 1)) - 1;
  localparam int RAD_MAX = (1 << RAD_WIDTH) - 1;

  typedef enum {QK_NEAR, QK_INSIDE, QK_RIM, QK_TIE, QK_WIDE} query_kind_t;
  typedef enum {RX_OPEN, RX_CHOPPY, RX_SLUGGISH} rx_mode_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [RAD_WIDTH-1:0]          box_half_size = '0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic signed [COORD_WIDTH-1:0] circle_x = '0;
  logic signed [COORD_WIDTH-1:0] circle_y = '0;
  logic [RAD_WIDTH-1:0]          circle_radius = '0;
  logic signed [COORD_WIDTH-1:0] box_x = '0;
  logic signed [COORD_WIDTH-1:0] box_y = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic                          hit;
  logic signed [COORD_WIDTH-1:0] push_x;
  logic signed [COORD_WIDTH-1:0] push_y;

  int       mismatch_count;
  int       outstanding;
  int       burst_left = 0;
  bit       gaps_on = 1'b1;
  int       queries_sent = 0;
  int       settings_used = 0;
  int       results_seen = 0;
  int       hits_seen = 0;
  int       idle_cycles = 0;
  int       cycle_count = 0;
  int       hold_left = 0;
  rx_mode_t rx_mode = RX_OPEN;

  circle_box_penetration uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .box_half_size (box_half_size),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .circle_x      (circle_x),
    .circle_y      (circle_y),
    .circle_radius (circle_radius),
    .box_x         (box_x),
    .box_y         (box_y),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .hit           (hit),
    .push_x        (push_x),
    .push_y        (push_y)
  );

  penetration_checker penetration_check (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .box_half_size  (box_half_size),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .circle_x       (circle_x),
    .circle_y       (circle_y),
    .circle_radius  (circle_radius),
    .box_x          (box_x),
    .box_y          (box_y),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .hit            (hit),
    .push_x         (push_x),
    .push_y         (push_y),
    .mismatch_count (mismatch_count),
    .outstanding    (outstanding)
  );

  // Free-running clock.
  initial begin
    forever #5 clk = ~clk;
  end

  // Result receiver: switches between always ready, random stalls and long stalls.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count % MODE_PERIOD == MODE_PERIOD - 1) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 2));
    end
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else begin
      case (rx_mode)
        RX_OPEN: begin
          out_ready <= 1'b1;
          hold_left <= 15;
        end
        RX_CHOPPY: begin
          out_ready <= ($urandom_range(0, 3) != 0);
          hold_left <= 0;
        end
        default: begin
          out_ready <= !out_ready;
          hold_left <= out_ready ? $urandom_range(1, 12) : $urandom_range(0, 5);
        end
      endcase
    end
  end

  // Result counts for the summary, and a watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if (out_valid && out_ready) begin
      results_seen <= results_seen + 1;
      if (hit) begin
        hits_seen <= hits_seen + 1;
      end
    end
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic int rand_coord();
    return int'($urandom_range(0, COORD_MAX - COORD_MIN)) + COORD_MIN;
  endfunction

  function automatic int rand_sign();
    return $urandom_range(0, 1) ? 1 : -1;
  endfunction

  function automatic query_kind_t pick_kind();
    int n;
    n = $urandom_range(0, 99);
    if (n < 45) return QK_NEAR;
    if (n < 55) return QK_INSIDE;
    if (n < 65) return QK_RIM;
    if (n < 75) return QK_TIE;
    return QK_WIDE;
  endfunction

  // Sends one query; the sender runs in bursts, with random gaps between them while gaps_on is set.
  task automatic send_query(input int cx, input int cy, input int r, input int bx,
                            input int by);
    if (burst_left == 0) begin
      if (gaps_on) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_valid <= 1'b1;
    circle_x <= COORD_WIDTH'(cx);
    circle_y <= COORD_WIDTH'(cy);
    circle_radius <= RAD_WIDTH'(r);
    box_x <= COORD_WIDTH'(bx);
    box_y <= COORD_WIDTH'(by);
    do @(posedge clk); while (!in_ready);
    burst_left--;
    queries_sent++;
  endtask

  // Stops sending and waits until every predicted result has come back.
  task automatic settle();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_half_size(input int half);
    cfg_valid <= 1'b1;
    box_half_size <= RAD_WIDTH'(half);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // One random query of the given shape, placed relative to a random box.
  task automatic send_random(input query_kind_t kind, input int half);
    int r;
    int d;
    int s;
    int ox;
    int oy;
    int bx;
    int by;
    bx = rand_coord();
    by = rand_coord();
    r = ($urandom_range(0, 9) == 0) ? $urandom_range(0, RAD_MAX) : $urandom_range(0, 700);
    ox = 0;
    oy = 0;
    case (kind)
      QK_NEAR: begin
        d = half + r + 8;
        ox = int'($urandom_range(0, 2 * d)) - d;
        oy = int'($urandom_range(0, 2 * d)) - d;
      end
      QK_INSIDE: begin
        ox = int'($urandom_range(0, 2 * half)) - half;
        oy = int'($urandom_range(0, 2 * half)) - half;
      end
      QK_RIM: begin
        // Center exactly one radius from the box, on an axis or on a 3-4-5 diagonal.
        if ($urandom_range(0, 1)) begin
          s = $urandom_range(0, 3);
          if (s == 0) ox = half + r;
          else if (s == 1) oy = half + r;
          else if (s == 2) ox = -(half + r);
          else oy = -(half + r);
        end else begin
          d = $urandom_range(0, 600);
          r = 5 * d;
          ox = rand_sign() * (half + 3 * d);
          oy = rand_sign() * (half + 4 * d);
        end
      end
      QK_TIE: begin
        // Equal offsets on both axes, so two directions tie.
        d = half + $urandom_range(1, 500);
        ox = rand_sign() * d;
        oy = rand_sign() * d;
        r = (d - half) * 3 / 2 + $urandom_range(0, 40);
      end
      default: begin
        ox = rand_coord();
        oy = rand_coord();
        r = $urandom_range(0, RAD_MAX);
      end
    endcase
    if (r > RAD_MAX) begin
      r = RAD_MAX;
    end
    send_query(bx + ox, by + oy, r, bx, by);
  endtask

  // Stimulus: directed cases per half size, then random phases.
  initial begin
    int half;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Half size from reset: center inside, far misses, rims, each direction, ties.
    send_query(0, 0, 100, 0, 0);
    send_query(COORD_MAX, COORD_MAX, 0, COORD_MIN, COORD_MIN);
    send_query(COORD_MIN, COORD_MIN, RAD_MAX, COORD_MAX, COORD_MAX);
    send_query(356, 0, 100, 0, 0);
    send_query(286, 296, 50, 0, 0);
    send_query(286, 296, 49, 0, 0);
    send_query(-300, 0, 100, 0, 0);
    send_query(0, -300, 100, 0, 0);
    send_query(300, 0, 100, 0, 0);
    send_query(0, 300, 100, 0, 0);
    send_query(-400, -400, 300, 0, 0);
    send_query(400, -400, 300, 0, 0);
    send_query(400, 400, 300, 0, 0);
    send_query(0, 0, 0, 0, 0);
    send_query(COORD_MAX, COORD_MIN, RAD_MAX, COORD_MAX, COORD_MIN);
    send_query(COORD_MIN, 0, RAD_MAX, 0, 0);

    // Point box.
    settle();
    write_half_size(0);
    send_query(10, 0, 10, 0, 0);
    send_query(0, 0, 5, 0, 0);
    send_query(COORD_MIN, COORD_MAX, RAD_MAX, COORD_MAX, COORD_MIN);

    // Largest box, with edges past the coordinate range.
    settle();
    write_half_size(RAD_MAX);
    send_query(COORD_MAX, COORD_MAX, RAD_MAX, COORD_MAX, COORD_MAX);
    send_query(0, 0, 50, COORD_MAX, COORD_MAX);
    send_query(-1, -1, 2, COORD_MAX, COORD_MAX);
    send_query(COORD_MIN, COORD_MIN, 100, COORD_MAX, COORD_MAX);

    // Random phases, each with its own half size; one in three runs without gaps.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      settle();
      case (phase)
        0: half = 1;
        1: half = RAD_MAX;
        2: half = 0;
        3: half = $urandom_range(0, 64);
        default: half = $urandom_range(0, 3000);
      endcase
      write_half_size(half);
      gaps_on = (phase % 3 != 1);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        send_random(pick_kind(), half);
      end
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d circle and box queries over %0d half-size writes.",
             queries_sent, settings_used);
    $display("Checked %0d results, %0d of them hits; %0d mismatches.",
             results_seen, hits_seen, mismatch_count);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

### circle_box_penetration.f
hdl/cbp_pkg.sv
hdl/cbp_front.sv
hdl/cbp_sqrt.sv
hdl/cbp_back.sv
hdl/circle_box_penetration.sv
hdl/cbp_checker.sv
tb/penetration_checker.sv
tb/circle_box_penetration_test.sv
